/* hw/rtl/umie_pkg.sv */
package umie_pkg;

    localparam int unsigned RegCount  = 8;
    localparam int unsigned RegIdxW   = 3;
    localparam int unsigned WordW     = 32;
    localparam int unsigned OpcodeLsb = 28;
    localparam int unsigned ImmRegLsb = 25;
    localparam int unsigned ImmW      = 25;

    typedef logic [WordW-1:0]   t_word;
    typedef logic [RegIdxW-1:0] t_ridx;

    typedef enum logic [3:0] {
        OP_CMOV = 4'd0, OP_LOAD = 4'd1, OP_STORE = 4'd2, OP_ADD = 4'd3,
        OP_MUL = 4'd4, OP_DIV = 4'd5, OP_NAND = 4'd6, OP_HALT = 4'd7,
        OP_MAP = 4'd8, OP_UNMAP = 4'd9, OP_OUT = 4'd10, OP_IN = 4'd11,
        OP_LDPROG = 4'd12, OP_LDIMM = 4'd13, OP_BAD14 = 4'd14, OP_BAD15 = 4'd15
    } t_opcode;

    typedef enum logic [3:0] {
        REQ_NONE = 4'd0, REQ_LOAD = 4'd1, REQ_STORE = 4'd2, REQ_MAP = 4'd3,
        REQ_UNMAP = 4'd4, REQ_OUTPUT = 4'd5, REQ_INPUT = 4'd6,
        REQ_LOADPROG = 4'd7, REQ_HALT = 4'd8, REQ_FAULT = 4'd9
    } t_req;

    // controller -> datapath
    typedef struct packed {
        logic latch;      // capture item, read operands
        logic div_start;  // load divider
        logic div_step;   // one quotient bit
        logic commit;     // write back, build result
        logic out_done;   // result taken
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_resp;
        logic is_div;
        logic div_zero;
        logic out_valid;
    } t_status;

endpackage

/* hw/rtl/umie_datapath.sv */
module umie_datapath import umie_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic        i_kind,
    input  t_word       i_word,
    input  t_word       i_resp,
    output t_status     o_status,
    output logic [3:0]  o_code,
    output t_word       o_op1,
    output t_word       o_op2,
    output t_word       o_op3,
    output t_word       o_next
);

    t_word       r_regs [RegCount];
    t_word       r_pc;
    t_ridx       r_pend;
    logic        r_await;
    logic        r_kind;
    t_word       r_word, r_resp, r_va, r_vb, r_vc;
    t_word       r_quo, r_rem;
    logic        r_ovalid;
    logic [3:0]  r_code;
    t_word       r_op1, r_op2, r_op3, r_next;

    t_opcode     w_op;
    t_ridx       w_a, w_b, w_c;
    logic [WordW:0] w_trial;

    // write-back and result, evaluated for the commit cycle
    logic        n_we;
    t_ridx       n_widx;
    t_word       n_wdata;
    logic        n_emit;
    logic [3:0]  n_code;
    t_word       n_op1, n_op2, n_op3, n_pc;
    t_ridx       n_pend;
    logic        n_await;

    assign w_op = t_opcode'(r_word[WordW-1:OpcodeLsb]);
    assign w_a  = r_word[8:6];
    assign w_b  = r_word[5:3];
    assign w_c  = r_word[2:0];
    assign w_trial = {r_rem, r_quo[WordW-1]} - {1'b0, r_vc};

    assign o_status = '{is_resp: r_kind, is_div: (w_op == OP_DIV) && !r_await,
                        div_zero: (r_vc == '0), out_valid: r_ovalid};
    assign o_code = r_code;
    assign o_op1  = r_op1;
    assign o_op2  = r_op2;
    assign o_op3  = r_op3;
    assign o_next = r_next;

    always_comb begin
        n_we    = 1'b0;
        n_widx  = w_a;
        n_wdata = '0;
        n_emit  = 1'b0;
        n_code  = REQ_NONE;
        n_op1   = '0;
        n_op2   = '0;
        n_op3   = '0;
        n_pc    = r_pc;
        n_pend  = r_pend;
        n_await = r_await;
        if (r_kind) begin
            if (r_await) begin
                n_we    = 1'b1;
                n_widx  = r_pend;
                n_wdata = r_resp;
                n_await = 1'b0;
            end
        end else if (!r_await) begin
            n_emit = 1'b1;
            n_pc   = r_pc + 32'd1;
            case (w_op)
                OP_CMOV: begin
                    n_we = (r_vc != '0); n_wdata = r_vb;
                end
                OP_LOAD: begin
                    n_code = REQ_LOAD; n_op1 = r_vb; n_op2 = r_vc;
                    n_pend = w_a; n_await = 1'b1;
                end
                OP_STORE: begin
                    n_code = REQ_STORE;
                    n_op1 = r_va; n_op2 = r_vb; n_op3 = r_vc;
                end
                OP_ADD: begin n_we = 1'b1; n_wdata = r_vb + r_vc; end
                OP_MUL: begin n_we = 1'b1; n_wdata = r_vb * r_vc; end
                OP_DIV: begin
                    if (r_vc == '0) begin
                        n_code = REQ_FAULT; n_pc = r_pc;
                    end else begin
                        n_we = 1'b1; n_wdata = r_quo;
                    end
                end
                OP_NAND: begin n_we = 1'b1; n_wdata = ~(r_vb & r_vc); end
                OP_HALT: begin
                    n_code = REQ_HALT; n_pc = r_pc;
                end
                OP_MAP: begin
                    n_code = REQ_MAP; n_op3 = r_vc;
                    n_pend = w_b; n_await = 1'b1;
                end
                OP_UNMAP: begin n_code = REQ_UNMAP; n_op3 = r_vc; end
                OP_OUT:   begin n_code = REQ_OUTPUT; n_op3 = r_vc; end
                OP_IN: begin
                    n_code = REQ_INPUT; n_pend = w_c; n_await = 1'b1;
                end
                OP_LDPROG: begin
                    n_code = REQ_LOADPROG; n_op1 = r_vb; n_op2 = r_vc;
                    n_pc = r_vc;
                end
                OP_LDIMM: begin
                    n_we    = 1'b1;
                    n_widx  = r_word[ImmRegLsb+RegIdxW-1:ImmRegLsb];
                    n_wdata = {{(WordW-ImmW){1'b0}}, r_word[ImmW-1:0]};
                end
                default: begin
                    n_code = REQ_FAULT; n_pc = r_pc;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_kind <= i_kind;
            r_word <= i_word;
            r_resp <= i_resp;
            r_va   <= r_regs[i_word[8:6]];
            r_vb   <= r_regs[i_word[5:3]];
            r_vc   <= r_regs[i_word[2:0]];
        end
        if (i_cmd.div_start) begin
            r_quo <= r_vb;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            if (!w_trial[WordW]) r_rem <= w_trial[WordW-1:0];
            else                 r_rem <= {r_rem[WordW-2:0], r_quo[WordW-1]};
            r_quo <= {r_quo[WordW-2:0], !w_trial[WordW]};
        end
        if (!i_rst_n) begin
            for (int i = 0; i < RegCount; i++) r_regs[i] <= '0;
            r_pc     <= '0;
            r_pend   <= '0;
            r_await  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            // a new result may land in the cycle the old one is taken
            if (i_cmd.commit && n_emit) r_ovalid <= 1'b1;
            else if (i_cmd.out_done)    r_ovalid <= 1'b0;
            if (i_cmd.commit) begin
                if (n_we) r_regs[n_widx] <= n_wdata;
                r_pc    <= n_pc;
                r_pend  <= n_pend;
                r_await <= n_await;
                if (n_emit) begin
                    r_code <= n_code;
                    r_op1  <= n_op1;
                    r_op2  <= n_op2;
                    r_op3  <= n_op3;
                    r_next <= n_pc;
                end
            end
        end
    end

endmodule

/* hw/rtl/umie_control.sv */
module umie_control import umie_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [1:0] {S_IDLE, S_DECODE, S_DIV, S_COMMIT} t_state;

    t_state     r_state, n_state;
    logic [4:0] r_cnt;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd = '0;
        n_state = r_state;
        o_cmd.out_done = i_status.out_valid && i_out_ready;
        case (r_state)
            S_IDLE: if (i_in_valid && o_in_ready) begin
                o_cmd.latch = 1'b1;
                n_state = S_DECODE;
            end
            S_DECODE: begin
                if (!i_status.is_resp && i_status.is_div && !i_status.div_zero) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end else n_state = S_COMMIT;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == 5'd31) n_state = S_COMMIT;
            end
            S_COMMIT: begin
                // hold write-back until the previous result is gone
                if (!i_status.out_valid || i_out_ready) begin
                    o_cmd.commit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DIV) r_cnt <= r_cnt + 5'd1;
            else                  r_cnt <= '0;
        end
    end

endmodule

/* hw/rtl/um_instruction_execute_unit.sv */
// Execute core of a 32-bit, 8-register universal machine.
// Slave channel (s_axis_*): one transfer per item. tuser = kind
// (0 instruction, 1 response value for the pending register).
// tdata = {response_value, instruction_word}, instruction in the low word.
// Master channel (m_axis_*): one transfer per executed instruction,
// tdata = request_code[3:0], operand_first, operand_second,
// operand_third, next_fetch_address, packed from the lowest bit, 4 pad
// bits at the top. Responses and ignored instructions produce nothing.
// Each item passes through decode and commit; a divide also runs the
// 32 steps of the one-bit-per-cycle restoring divider between them.
// One item at a time: a new item is accepted once the previous one has
// committed.
// Reset (synchronous, i_rst_n low) clears the register file, counter,
// pending state and output valid.
// A stalled receiver holds the result steady; the next item is still
// accepted and decoded, but its commit waits until the result is taken.
module um_instruction_execute_unit import umie_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [63:0]   s_axis_tdata,  // instruction_word, response_value
    input  logic          s_axis_tuser,  // kind
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // request_code, operand_first, operand_second, operand_third, next_fetch_address
    output logic [135:0]  m_axis_tdata
);

    t_cmd       w_cmd;
    t_status    w_status;
    logic [3:0] w_code;
    t_word      w_op1, w_op2, w_op3, w_next;

    umie_control u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .i_out_ready(m_axis_tready), .i_status(w_status), .o_cmd(w_cmd)
    );

    umie_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd),
        .i_kind(s_axis_tuser), .i_word(s_axis_tdata[31:0]),
        .i_resp(s_axis_tdata[63:32]), .o_status(w_status),
        .o_code(w_code), .o_op1(w_op1), .o_op2(w_op2), .o_op3(w_op3),
        .o_next(w_next)
    );

    assign m_axis_tvalid = w_status.out_valid;
    assign m_axis_tdata  = {4'b0, w_next, w_op3, w_op2, w_op1, w_code};

endmodule
